@@ hdl/sgm_pkg.sv @@
// Shared types and constants of the Sobel gradient magnitude block.
// No dependencies; used by sgm_sqrt and sobel_gradient_magnitude.
package sgm_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int CHANNEL_BITS = 8;
    localparam int ADDR_W       = $clog2(MAX_WIDTH);
    localparam int GEOM_W       = 12;
    localparam int SUMSQ_W      = 21;
    localparam int ROOT_IN_W    = 2 * CHANNEL_BITS;

    // Configuration register indexes
    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef logic [4*CHANNEL_BITS-1:0] pixel_t;
    typedef logic [SUMSQ_W-1:0]        sumsq_t;
    typedef logic [CHANNEL_BITS-1:0]   chan_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DRAIN_RD,
        S_PIX_RD,
        S_GRAD,
        S_SQRT,
        S_FIN
    } state_t;

endpackage

@@ hdl/sgm_sqrt.sv @@
// Three-lane iterative integer square root, one result bit per cycle.
// Saturates to 255 for inputs of 65536 and above. Depends on sgm_pkg.
module sgm_sqrt import sgm_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   start,
    input  sumsq_t sumsq [3],
    output logic   done,
    output chan_t  root [3]
);

    logic [ROOT_IN_W-1:0] rem_reg  [3];
    logic [ROOT_IN_W-1:0] rem_next [3];
    logic [ROOT_IN_W-1:0] res_reg  [3];
    logic [ROOT_IN_W-1:0] res_next [3];
    logic                 sat_reg  [3];
    logic [ROOT_IN_W-1:0] bit_reg;
    logic                 busy_reg;
    logic                 done_reg;

    // One digit step per lane
    always_comb begin
        logic [ROOT_IN_W:0] trial;
        for (int k = 0; k < 3; k++) begin
            trial = {1'b0, res_reg[k]} + {1'b0, bit_reg};
            if ({1'b0, rem_reg[k]} >= trial) begin
                rem_next[k] = rem_reg[k] - trial[ROOT_IN_W-1:0];
                res_next[k] = (res_reg[k] >> 1) + bit_reg;
            end else begin
                rem_next[k] = rem_reg[k];
                res_next[k] = res_reg[k] >> 1;
            end
        end
    end

    // Control: load on start, iterate until the last digit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg == ROOT_IN_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            bit_reg <= ROOT_IN_W'(1) << (ROOT_IN_W - 2);
            for (int k = 0; k < 3; k++) begin
                rem_reg[k] <= sumsq[k][ROOT_IN_W-1:0];
                res_reg[k] <= '0;
                sat_reg[k] <= |sumsq[k][SUMSQ_W-1:ROOT_IN_W];
            end
        end else if (busy_reg) begin
            bit_reg <= bit_reg >> 2;
            for (int k = 0; k < 3; k++) begin
                rem_reg[k] <= rem_next[k];
                res_reg[k] <= res_next[k];
            end
        end
    end

    assign done = done_reg;
    always_comb begin
        for (int k = 0; k < 3; k++)
            root[k] = sat_reg[k] ? '1 : res_reg[k][CHANNEL_BITS-1:0];
    end

endmodule

@@ hdl/sobel_gradient_magnitude.sv @@
// Top level of the streaming 3x3 Sobel gradient magnitude block.
// Depends on sgm_pkg and sgm_sqrt.
//
// Pixels enter on the s_ channel in raster order (s_kind = 0); drain words
// (s_kind = 1) flush the pixels still held once the last pixel of a frame
// is in. Results leave on the m_ channel; m_frame_end marks the last one.
// A pixel comes out one line plus one pixel after it went in.
// One word is worked on at a time. A pass-through or border pixel passes
// the pixel read state, a drain word from the lower store the drain read
// state, and a drain word of the right-border pixel goes straight to the
// finish state; an interior pixel with the operator on also passes the
// gradient stage and the eight-step square root. The input is free again
// in the cycle after the result register loads. A pixel that causes no
// result frees the input after the pixel read state, a drain word at once.
// Both line stores have registered reads, addressed in the cycle before
// use, with one write and one read a cycle.
// Reset clears the position, the drain count, the window and the output
// valid flag; line store contents are unspecified until written in a frame.
// A stalled receiver holds the result register; the block finishes the
// next word and then waits until the register is free.
// The user must write configuration through cfg_wr_en/cfg_addr/cfg_wdata
// only while idle, unenforced; a width or height write restarts the frame.
module sobel_gradient_magnitude import sgm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_addr,
    input  logic [GEOM_W-1:0] cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_kind,
    input  logic [7:0]        s_blue_in,
    input  logic [7:0]        s_green_in,
    input  logic [7:0]        s_red_in,
    input  logic [7:0]        s_alpha_in,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_blue_out,
    output logic [7:0]        m_green_out,
    output logic [7:0]        m_red_out,
    output logic [7:0]        m_alpha_out,
    output logic              m_frame_end
);

    state_t state_reg, state_next;

    logic              enable_reg;
    logic [GEOM_W-1:0] width_reg;
    logic [GEOM_W-1:0] height_reg;
    logic [ADDR_W-1:0] col_reg;
    logic [GEOM_W-1:0] row_reg;
    logic [GEOM_W-1:0] pending_reg;
    logic [ADDR_W-1:0] cur_col_reg;
    logic [GEOM_W-1:0] cur_row_reg;
    pixel_t            cur_reg;
    pixel_t            last_upper_reg;
    pixel_t            res_reg;
    logic              res_fend_reg;
    logic              border_reg;
    logic              centre_reg;
    pixel_t            win_reg [9];

    pixel_t            upper_mem [MAX_WIDTH];
    pixel_t            lower_mem [MAX_WIDTH];
    pixel_t            upper_rd;
    pixel_t            lower_rd;
    logic [ADDR_W-1:0] rd_addr;

    logic              m_valid_reg;
    pixel_t            m_pix_reg;
    logic              m_fend_reg;

    logic [GEOM_W-1:0] w_eff, h_eff;
    logic [ADDR_W-1:0] c_in;
    logic [GEOM_W-1:0] r_in;
    logic              accept, out_free, interior, sq_start, sq_done;
    sumsq_t            sumsq [3];
    chan_t             root  [3];

    // Effective geometry
    always_comb begin
        if (width_reg == '0)
            w_eff = GEOM_W'(1);
        else if (width_reg > GEOM_W'(MAX_WIDTH))
            w_eff = GEOM_W'(MAX_WIDTH);
        else
            w_eff = width_reg;
        h_eff = (height_reg == '0) ? GEOM_W'(1) : height_reg;
    end

    // Position of the incoming pixel, wrapped when out of the frame
    always_comb begin
        if ({1'b0, col_reg} >= w_eff || row_reg >= h_eff) begin
            c_in = '0;
            r_in = '0;
        end else begin
            c_in = col_reg;
            r_in = row_reg;
        end
    end

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign interior = cur_row_reg >= GEOM_W'(2) && cur_col_reg >= ADDR_W'(2);

    // Read address: pixel column, or drain position in the lower store
    always_comb begin
        if (s_kind)
            rd_addr = ADDR_W'(w_eff - pending_reg);
        else
            rd_addr = c_in;
    end

    // Line stores
    always_ff @(posedge aclk) begin
        if (state_reg == S_PIX_RD) begin
            upper_mem[cur_col_reg] <= lower_rd;
            lower_mem[cur_col_reg] <= cur_reg;
        end
        upper_rd <= upper_mem[rd_addr];
        lower_rd <= lower_mem[rd_addr];
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (!s_kind)
                        state_next = S_PIX_RD;
                    else if (pending_reg != '0)
                        state_next = (pending_reg > w_eff) ? S_FIN : S_DRAIN_RD;
                end
            end
            S_DRAIN_RD: state_next = S_FIN;
            S_PIX_RD: begin
                priority if (centre_reg)
                    state_next = (interior && enable_reg) ? S_GRAD : S_FIN;
                else if (border_reg)
                    state_next = S_FIN;
                else
                    state_next = S_IDLE;
            end
            S_GRAD: state_next = S_SQRT;
            S_SQRT: begin
                if (sq_done) state_next = S_FIN;
            end
            S_FIN: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_ready  = (state_reg == S_IDLE);
        sq_start = (state_reg == S_GRAD);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    // Gradients and squared magnitude per channel
    always_comb begin
        logic signed [GEOM_W-1:0] gx, gy;
        logic [9:0]               ax, ay;
        for (int k = 0; k < 3; k++) begin
            gx = GEOM_W'({4'd0, win_reg[2][8*k +: 8]})
               + GEOM_W'({3'd0, win_reg[5][8*k +: 8], 1'b0})
               + GEOM_W'({4'd0, win_reg[8][8*k +: 8]})
               - GEOM_W'({4'd0, win_reg[0][8*k +: 8]})
               - GEOM_W'({3'd0, win_reg[3][8*k +: 8], 1'b0})
               - GEOM_W'({4'd0, win_reg[6][8*k +: 8]});
            gy = GEOM_W'({4'd0, win_reg[6][8*k +: 8]})
               + GEOM_W'({3'd0, win_reg[7][8*k +: 8], 1'b0})
               + GEOM_W'({4'd0, win_reg[8][8*k +: 8]})
               - GEOM_W'({4'd0, win_reg[0][8*k +: 8]})
               - GEOM_W'({3'd0, win_reg[1][8*k +: 8], 1'b0})
               - GEOM_W'({4'd0, win_reg[2][8*k +: 8]});
            ax = gx[GEOM_W-1] ? 10'(-gx) : 10'(gx);
            ay = gy[GEOM_W-1] ? 10'(-gy) : 10'(gy);
            sumsq[k] = SUMSQ_W'(ax * ax) + SUMSQ_W'(ay * ay);
        end
    end

    sgm_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .sumsq   (sumsq),
        .done    (sq_done),
        .root    (root)
    );

    // Control registers: configuration, position, drain count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg  <= 1'b0;
            width_reg   <= GEOM_W'(640);
            height_reg  <= GEOM_W'(480);
            col_reg     <= '0;
            row_reg     <= '0;
            pending_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_ENABLE: enable_reg <= cfg_wdata[0];
                REG_WIDTH: begin
                    width_reg   <= cfg_wdata;
                    col_reg     <= '0;
                    row_reg     <= '0;
                    pending_reg <= '0;
                end
                REG_HEIGHT: begin
                    height_reg  <= cfg_wdata;
                    col_reg     <= '0;
                    row_reg     <= '0;
                    pending_reg <= '0;
                end
                default: ;
            endcase
        end else if (accept) begin
            if (s_kind) begin
                if (pending_reg != '0) pending_reg <= pending_reg - 1'b1;
            end else begin
                pending_reg <= '0;
                if (GEOM_W'(c_in) + 1'b1 >= w_eff && r_in + 1'b1 >= h_eff) begin
                    pending_reg <= (h_eff == GEOM_W'(1)) ? w_eff : w_eff + 1'b1;
                    col_reg     <= '0;
                    row_reg     <= '0;
                end else if (GEOM_W'(c_in) + 1'b1 >= w_eff) begin
                    col_reg <= '0;
                    row_reg <= r_in + 1'b1;
                end else begin
                    col_reg <= c_in + 1'b1;
                    row_reg <= r_in;
                end
            end
        end
    end

    // Word flags and window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            border_reg <= 1'b0;
            centre_reg <= 1'b0;
            for (int i = 0; i < 9; i++) win_reg[i] <= '0;
        end else begin
            if (accept && !s_kind) begin
                border_reg <= (c_in == '0) && (r_in >= GEOM_W'(2));
                centre_reg <= (c_in != '0) && (r_in != '0);
            end
            if (state_reg == S_PIX_RD) begin
                for (int i = 0; i < 3; i++) begin
                    win_reg[3*i]     <= win_reg[3*i + 1];
                    win_reg[3*i + 1] <= win_reg[3*i + 2];
                end
                win_reg[2] <= upper_rd;
                win_reg[5] <= lower_rd;
                win_reg[8] <= cur_reg;
            end
        end
    end

    // Payload: current pixel, right-border copy, pending result
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (s_kind) begin
                res_reg      <= last_upper_reg;
                res_fend_reg <= (pending_reg == GEOM_W'(1));
            end else begin
                cur_reg      <= {s_alpha_in, s_red_in, s_green_in, s_blue_in};
                cur_col_reg  <= c_in;
                cur_row_reg  <= r_in;
                res_reg      <= last_upper_reg;
                res_fend_reg <= 1'b0;
            end
        end
        if (state_reg == S_DRAIN_RD)
            res_reg <= lower_rd;
        if (state_reg == S_PIX_RD) begin
            if (GEOM_W'(cur_col_reg) == w_eff - 1'b1)
                last_upper_reg <= lower_rd;
            if (centre_reg)
                res_reg <= win_reg[5];
        end
        if (state_reg == S_SQRT && sq_done)
            res_reg <= {win_reg[4][31:24], root[2], root[1], root[0]};
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_FIN && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_FIN && out_free) begin
            m_pix_reg  <= res_reg;
            m_fend_reg <= res_fend_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_blue_out  = m_pix_reg[7:0];
    assign m_green_out = m_pix_reg[15:8];
    assign m_red_out   = m_pix_reg[23:16];
    assign m_alpha_out = m_pix_reg[31:24];
    assign m_frame_end = m_fend_reg;

endmodule

@@ test/sobel_gradient_magnitude_test.sv @@
// Self-checking bench for the streaming Sobel gradient magnitude block.
// Depends on sgm_pkg and the sobel_gradient_magnitude RTL; needs no files.
// A directed table, then random frames, all checked against a local edge model.
module sobel_gradient_magnitude_test;
    import sgm_pkg::*;

    localparam int TIMEOUT_CYCLES = 4_000_000;
    localparam int SETTLE_CYCLES  = 24;

    typedef enum logic [1:0] {
        OP_PIXEL,
        OP_DRAIN,
        OP_CONFIG
    } stim_op_e;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
        logic       frame_end;
    } edge_word_t;

    typedef struct {
        stim_op_e    op;
        logic [1:0]  reg_idx;
        logic [11:0] reg_val;
        pixel_t      px;
        bit          typed;
        edge_word_t  want;
    } stim_row_t;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [1:0]        cfg_addr    = REG_ENABLE;
    logic [GEOM_W-1:0] cfg_wdata   = '0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic              s_kind      = 1'b0;
    logic [7:0]        s_blue_in   = '0;
    logic [7:0]        s_green_in  = '0;
    logic [7:0]        s_red_in    = '0;
    logic [7:0]        s_alpha_in  = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic [7:0]        m_blue_out;
    logic [7:0]        m_green_out;
    logic [7:0]        m_red_out;
    logic [7:0]        m_alpha_out;
    logic              m_frame_end;

    sobel_gradient_magnitude u_top (.*);

    // Local copy of the edge pipeline state
    pixel_t      upper_line [MAX_WIDTH];
    pixel_t      lower_line [MAX_WIDTH];
    pixel_t      win [3][3];
    int unsigned col_pos, row_pos, drain_left;
    bit          edge_on;
    logic [11:0] width_reg, height_reg;

    edge_word_t  pending_words [$];
    stim_row_t   directed_rows [$];
    int          mismatches   = 0;
    int          table_errors = 0;
    int          cycle_count  = 0;
    int          words_sent;
    int          burst_left;
    bit          typed_on     = 1'b0;
    edge_word_t  typed_word;

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Floor square root, one result bit per pass from the top
    function automatic int unsigned floor_root(input int unsigned v);
        int unsigned res;
        int unsigned trial;
        res = 0;
        for (int b = 15; b >= 0; b--) begin
            trial = res | (1 << b);
            if (trial * trial <= v) res = trial;
        end
        return res;
    endfunction

    function automatic edge_word_t to_word(input pixel_t px, input bit fend);
        edge_word_t w;
        w.blue      = px[7:0];
        w.green     = px[15:8];
        w.red       = px[23:16];
        w.alpha     = px[31:24];
        w.frame_end = fend;
        return w;
    endfunction

    function automatic pixel_t gradient_pixel();
        pixel_t      outpx;
        int          p [3][3];
        int          gx, gy;
        int unsigned m;
        outpx = {win[1][1][31:24], 24'd0};
        for (int k = 0; k < 3; k++) begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    p[r][c] = int'(win[r][c][8*k +: 8]);
            gx = (p[0][2] + 2*p[1][2] + p[2][2]) - (p[0][0] + 2*p[1][0] + p[2][0]);
            gy = (p[2][0] + 2*p[2][1] + p[2][2]) - (p[0][0] + 2*p[0][1] + p[0][2]);
            m = floor_root(gx*gx + gy*gy);
            if (m > 255) m = 255;
            outpx[8*k +: 8] = m[7:0];
        end
        return outpx;
    endfunction

    // Advance the local pipeline by one accepted word; queue any result
    function automatic void predict_word(input bit is_drain, input pixel_t cur);
        int unsigned w, h, c, r, orow, ocol;
        bit          interior;
        pixel_t      px;
        w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        h = (height_reg == 0) ? 1 : height_reg;
        if (is_drain) begin
            if (drain_left == 0) return;
            px = (drain_left > w) ? upper_line[w-1] : lower_line[w-drain_left];
            drain_left--;
            pending_words.push_back(to_word(px, drain_left == 0));
            return;
        end
        drain_left = 0;
        c = col_pos;
        r = row_pos;
        if (c >= w || r >= h) begin
            c = 0;
            r = 0;
        end
        // right border pixel of two lines up leaves before its slot is reused
        if (c == 0 && r >= 2) pending_words.push_back(to_word(upper_line[w-1], 1'b0));
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = upper_line[c];
        win[1][2] = lower_line[c];
        win[2][2] = cur;
        upper_line[c] = lower_line[c];
        lower_line[c] = cur;
        if (c >= 1 && r >= 1) begin
            orow = r - 1;
            ocol = c - 1;
            interior = orow >= 1 && orow + 2 <= h && ocol >= 1 && ocol + 2 <= w;
            px = (interior && edge_on) ? gradient_pixel() : win[1][1];
            pending_words.push_back(to_word(px, 1'b0));
        end
        if (c + 1 >= w && r + 1 >= h) begin
            drain_left = (h == 1) ? w : w + 1;
            col_pos = 0;
            row_pos = 0;
        end else if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t px;
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 7))
                0: px[8*k +: 8] = 8'h00;
                1: px[8*k +: 8] = 8'hFF;
                default: px[8*k +: 8] = 8'($urandom);
            endcase
        end
        return px;
    endfunction

    function automatic void add_row(input stim_op_e op, input logic [1:0] idx,
                                    input logic [11:0] val, input pixel_t px,
                                    input bit typed, input edge_word_t want);
        stim_row_t row;
        row.op      = op;
        row.reg_idx = idx;
        row.reg_val = val;
        row.px      = px;
        row.typed   = typed;
        row.want    = want;
        directed_rows.push_back(row);
    endfunction

    // Drop valid and hold until every expected word is out, then settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_ENABLE: edge_on = val[0];
            default: begin
                if (idx == REG_WIDTH) width_reg = val;
                else height_reg = val;
                col_pos    = 0;
                row_pos    = 0;
                drain_left = 0;
            end
        endcase
    endtask

    // Present one word, hold until taken, then maybe open a gap
    task automatic send_word(input bit is_drain, input pixel_t px);
        int gap;
        int before_n;
        s_valid    <= 1'b1;
        s_kind     <= is_drain;
        s_blue_in  <= px[7:0];
        s_green_in <= px[15:8];
        s_red_in   <= px[23:16];
        s_alpha_in <= px[31:24];
        do @(posedge aclk); while (!s_ready);
        before_n = pending_words.size();
        predict_word(is_drain, px);
        // a typed row replaces the predicted word before it can leave
        if (typed_on) begin
            if (pending_words.size() == before_n + 1) begin
                pending_words[$] = typed_word;
            end else begin
                $error("typed row: no result word predicted for this input");
                table_errors++;
            end
            typed_on = 1'b0;
        end
        words_sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_frame(input int unsigned w, input int unsigned h);
        for (int unsigned i = 0; i < w * h; i++) send_word(1'b0, rand_pixel());
        for (int unsigned i = 0; i <= w; i++) send_word(1'b1, rand_pixel());
    endtask

    // Receiver stalls: busy spells alternate with clean ones
    always @(posedge aclk) begin
        if (cycle_count[9]) m_ready <= ($urandom_range(0, 3) != 0);
        else if (cycle_count[8]) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 1) != 0);
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge aclk) begin
        edge_word_t exp_w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                $error("unexpected result word: blue %0d green %0d red %0d alpha %0d",
                       m_blue_out, m_green_out, m_red_out, m_alpha_out);
                mismatches++;
            end else begin
                exp_w = pending_words.pop_front();
                if (m_blue_out !== exp_w.blue) begin
                    $error("blue_out: expected %0d, got %0d", exp_w.blue, m_blue_out);
                    mismatches++;
                end
                if (m_green_out !== exp_w.green) begin
                    $error("green_out: expected %0d, got %0d", exp_w.green, m_green_out);
                    mismatches++;
                end
                if (m_red_out !== exp_w.red) begin
                    $error("red_out: expected %0d, got %0d", exp_w.red, m_red_out);
                    mismatches++;
                end
                if (m_alpha_out !== exp_w.alpha) begin
                    $error("alpha_out: expected %0d, got %0d", exp_w.alpha, m_alpha_out);
                    mismatches++;
                end
                if (m_frame_end !== exp_w.frame_end) begin
                    $error("frame_end: expected %0d, got %0d",
                           exp_w.frame_end, m_frame_end);
                    mismatches++;
                end
            end
        end
    end

    // Abandon a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        edge_word_t  none;
        stim_row_t   row;
        int unsigned w, h, frames, mode, cut;
        logic [11:0] wv, hv;
        bit          paused;

        none        = '0;
        words_sent  = 0;
        burst_left  = 0;
        paused      = 1'b0;
        foreach (win[i, j]) win[i][j] = '0;
        col_pos    = 0;
        row_pos    = 0;
        drain_left = 0;
        edge_on    = 1'b0;
        width_reg  = 12'd640;
        height_reg = 12'd480;

        // Single pixel frames: pass-through, stray drains, restart over pending
        add_row(OP_CONFIG, REG_WIDTH, 12'd1, '0, 1'b0, none);
        add_row(OP_CONFIG, REG_HEIGHT, 12'd1, '0, 1'b0, none);
        add_row(OP_CONFIG, REG_ENABLE, 12'd0, '0, 1'b0, none);
        add_row(OP_DRAIN, REG_ENABLE, 12'd0, '0, 1'b0, none);
        add_row(OP_PIXEL, REG_ENABLE, 12'd0, 32'hFFFF_FFFF, 1'b0, none);
        add_row(OP_DRAIN, REG_ENABLE, 12'd0, '0, 1'b1,
                '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1});
        add_row(OP_DRAIN, REG_ENABLE, 12'd0, '0, 1'b0, none);
        add_row(OP_PIXEL, REG_ENABLE, 12'd0, 32'h0000_0000, 1'b0, none);
        add_row(OP_PIXEL, REG_ENABLE, 12'd0, 32'h7856_3412, 1'b0, none);
        add_row(OP_DRAIN, REG_ENABLE, 12'd0, '0, 1'b1,
                '{8'h12, 8'h34, 8'h56, 8'h78, 1'b1});
        // 3x3 checkerboard with the operator on: one interior pixel
        add_row(OP_CONFIG, REG_WIDTH, 12'd3, '0, 1'b0, none);
        add_row(OP_CONFIG, REG_HEIGHT, 12'd3, '0, 1'b0, none);
        add_row(OP_CONFIG, REG_ENABLE, 12'd1, '0, 1'b0, none);
        for (int i = 0; i < 9; i++)
            add_row(OP_PIXEL, REG_ENABLE, 12'd0,
                    (i % 2) ? 32'h00FF_FFFF : {8'(i * 29), 24'h0}, 1'b0, none);
        for (int i = 0; i < 4; i++)
            add_row(OP_DRAIN, REG_ENABLE, 12'd0, '0, 1'b0, none);
        // Zero geometry acts as one
        add_row(OP_CONFIG, REG_WIDTH, 12'd0, '0, 1'b0, none);
        add_row(OP_CONFIG, REG_HEIGHT, 12'd0, '0, 1'b0, none);
        add_row(OP_PIXEL, REG_ENABLE, 12'd0, 32'hA5C3_3C5A, 1'b0, none);
        add_row(OP_DRAIN, REG_ENABLE, 12'd0, '0, 1'b1,
                '{8'h5A, 8'h3C, 8'hC3, 8'hA5, 1'b1});

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            typed_on   = row.typed;
            typed_word = row.want;
            case (row.op)
                OP_CONFIG: write_reg(row.reg_idx, row.reg_val);
                OP_PIXEL:  send_word(1'b0, row.px);
                default:   send_word(1'b1, row.px);
            endcase
        end

        // Random phases of small frames, mostly complete, some cut or noisy
        while (words_sent < 830) begin
            case ($urandom_range(0, 9))
                0: wv = 12'd0;
                1: wv = 12'($urandom_range(9, 40));
                default: wv = 12'($urandom_range(1, 8));
            endcase
            hv = ($urandom_range(0, 9) == 0) ? 12'd0 : 12'($urandom_range(1, 6));
            write_reg(REG_ENABLE, 12'($urandom_range(0, 1)));
            if ($urandom_range(0, 1)) begin
                write_reg(REG_WIDTH, wv);
                write_reg(REG_HEIGHT, hv);
            end else begin
                write_reg(REG_HEIGHT, hv);
                write_reg(REG_WIDTH, wv);
            end
            w = (wv == 0) ? 1 : wv;
            h = (hv == 0) ? 1 : hv;
            frames = $urandom_range(1, 4);
            for (int f = 0; f < frames && words_sent < 830; f++) begin
                mode = $urandom_range(0, 9);
                if (mode == 0) begin
                    cut = $urandom_range(0, w * h - 1);
                    for (int unsigned i = 0; i < cut; i++) send_word(1'b0, rand_pixel());
                    repeat ($urandom_range(0, 2)) send_word(1'b1, rand_pixel());
                end else if (mode == 1) begin
                    repeat ($urandom_range(1, 3)) send_word(1'b1, rand_pixel());
                end else begin
                    send_frame(w, h);
                    if ($urandom_range(0, 3) == 0) send_word(1'b1, rand_pixel());
                end
            end
            // hold the sender once until the pipeline has emptied
            if (!paused && words_sent > 400) begin
                wait_idle();
                paused = 1'b1;
            end
        end

        // Widest and tallest geometry, and width above the store depth,
        // on cut frames, then one complete 4x4 frame
        write_reg(REG_ENABLE, 12'd1);
        write_reg(REG_WIDTH, 12'd2048);
        write_reg(REG_HEIGHT, 12'd3);
        for (int i = 0; i < 40; i++) send_word(1'b0, rand_pixel());
        send_word(1'b1, rand_pixel());
        write_reg(REG_ENABLE, 12'd0);
        write_reg(REG_WIDTH, 12'd4095);
        write_reg(REG_HEIGHT, 12'd2);
        for (int i = 0; i < 40; i++) send_word(1'b0, rand_pixel());
        write_reg(REG_ENABLE, 12'd1);
        write_reg(REG_WIDTH, 12'd1);
        write_reg(REG_HEIGHT, 12'd4095);
        for (int i = 0; i < 40; i++) send_word(1'b0, rand_pixel());
        send_word(1'b1, rand_pixel());
        write_reg(REG_WIDTH, 12'd4);
        write_reg(REG_HEIGHT, 12'd4);
        send_frame(4, 4);

        wait_idle();
        if (mismatches == 0 && table_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
